// ===== hdl/bbcm_pkg.sv =====
// Package for the blob centroid marker: sizes, sequencer states, register
// indexes, status struct and the frame size clamp.
// No dependencies.
`default_nettype none

package bbcm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ARM_LENGTH = 10;

  localparam int DIM_W   = 11;  // frame size register width
  localparam int COORD_W = 10;  // column / row / centroid width
  localparam int SUM_W   = 30;  // coordinate sums
  localparam int CNT_W   = 21;  // object pixel count
  localparam int OFF_W   = 22;  // signed linear offset
  localparam int LIM_W   = 21;  // width*height and centroid base
  localparam int PIX_W   = 8;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int IDX_W   = $clog2(2 * ARM_LENGTH + 1);
  localparam int DSTEP_W = $clog2(COORD_W);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_DIV_X,
    SEQ_DIV_Y,
    SEQ_MUL_BASE,
    SEQ_MUL_LIMIT,
    SEQ_MUL_ARM,
    SEQ_EMIT_ROW,
    SEQ_EMIT_COL,
    SEQ_EMPTY
  } seq_state_t;

  typedef struct packed {
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic [CNT_W-1:0] count;
  } acc_stat_t;

  // zero reads as 1, anything above the maximum saturates
  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bbcm_accum.sv =====
// Raster position tracking and zero-pixel accumulation for one frame.
// Depends on bbcm_pkg.
`default_nettype none

module bbcm_accum
  import bbcm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             clear,
  input  wire logic [PIX_W-1:0] pixel,
  input  wire logic [DIM_W-1:0] width,
  input  wire logic [DIM_W-1:0] height,
  output acc_stat_t             stat,
  output logic                  end_frame
);

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0]   csum_r, csum_nxt;
  logic [SUM_W-1:0]   rsum_r, rsum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [DIM_W-1:0] col_a, row_a, row_b, col_inc, row_inc;

  always_comb begin
    // a column left beyond a shrunken width wraps into the next row
    if ({1'b0, col_r} >= width) begin
      col_a = '0;
      row_a = {1'b0, row_r} + DIM_W'(1);
    end else begin
      col_a = {1'b0, col_r};
      row_a = {1'b0, row_r};
    end
    row_b   = (row_a >= height) ? height - DIM_W'(1) : row_a;
    col_inc = col_a + DIM_W'(1);
    row_inc = row_b + DIM_W'(1);

    csum_nxt = csum_r;
    rsum_nxt = rsum_r;
    cnt_nxt  = cnt_r;
    if (pixel == '0) begin
      csum_nxt = csum_r + SUM_W'(col_a);
      rsum_nxt = rsum_r + SUM_W'(row_b);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end

    end_frame = 1'b0;
    if (col_inc >= width) begin
      col_nxt = '0;
      if (row_inc >= height) begin
        end_frame = 1'b1;
        row_nxt   = row_b[COORD_W-1:0];
      end else begin
        row_nxt = row_inc[COORD_W-1:0];
      end
    end else begin
      col_nxt = col_inc[COORD_W-1:0];
      row_nxt = row_b[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      col_r  <= '0;
      row_r  <= '0;
      csum_r <= '0;
      rsum_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      csum_r <= csum_nxt;
      rsum_r <= rsum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign stat.col_sum = csum_r;
  assign stat.row_sum = rsum_r;
  assign stat.count   = cnt_r;

endmodule

`default_nettype wire

// ===== hdl/bbcm_div.sv =====
// Shared restoring divider, one quotient bit per cycle, COORD_W quotient bits.
// The quotient is known to fit COORD_W bits (a mean coordinate).
// Depends on bbcm_pkg.
`default_nettype none

module bbcm_div
  import bbcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [CNT_W-1:0]   divisor,
  output logic                    done,
  output logic [COORD_W-1:0]      quotient
);

  logic                 run_r;
  logic                 done_r;
  logic [DSTEP_W-1:0]   step_r;
  logic [CNT_W-1:0]     rem_r;
  logic [COORD_W-1:0]   low_r;
  logic [COORD_W-1:0]   quo_r;
  logic [CNT_W-1:0]     div_r;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           qbit;

  always_comb begin
    trial = {rem_r, low_r[COORD_W-1]};
    diff  = trial - {1'b0, div_r};
    qbit  = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + DSTEP_W'(1);
        if (step_r == DSTEP_W'(COORD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // upper dividend bits start as the remainder: they are below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CNT_W'(dividend[SUM_W-1:COORD_W]);
      low_r <= dividend[COORD_W-1:0];
      div_r <= divisor;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      low_r <= {low_r[COORD_W-2:0], 1'b0};
      quo_r <= {quo_r[COORD_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hdl/binary_blob_centroid_marker.sv =====
// Blob centroid marker. Mid-frame pixels: one per cycle, busy stays low.
// The frame's last pixel raises busy until the last marker beat is issued:
// two 10-step divisions on the shared divider, three multiplies on one
// shared multiplier, then 42 marker beats one per cycle (an empty frame
// gives a single beat instead). Results cannot be stalled.
// Synchronous active-low reset: sizes 640x480, counters and sums cleared.
`default_nettype none

module binary_blob_centroid_marker
  import bbcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [PIX_W-1:0]        in_pixel,
  output logic                         out_valid,
  output logic signed [OFF_W-1:0]      out_write_offset,
  output logic                         out_in_frame,
  output logic [COORD_W-1:0]           out_centroid_x,
  output logic [COORD_W-1:0]           out_centroid_y,
  output logic                         out_found,
  output logic                         out_last,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   paddr,
  input  wire logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0] cfg_width_r, cfg_height_r;
  logic [DIM_W-1:0] width_eff, height_eff;
  cfg_idx_t         cfg_idx;
  logic             cfg_wr;

  assign cfg_idx = cfg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= DIM_W'(640);
      cfg_height_r <= DIM_W'(480);
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_FRAME_WIDTH:  cfg_width_r  <= pwdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_FRAME_WIDTH:  prdata = CFG_DATA_W'(cfg_width_r);
      CFG_FRAME_HEIGHT: prdata = CFG_DATA_W'(cfg_height_r);
      default:          prdata = '0;
    endcase
  end

  assign width_eff  = clamp_size(cfg_width_r, DIM_W'(MAX_WIDTH));
  assign height_eff = clamp_size(cfg_height_r, DIM_W'(MAX_HEIGHT));

  // ---------------- accumulation ----------------
  seq_state_t state_r, state_nxt;
  logic       accept;
  logic       acc_clear;
  logic       end_frame;
  acc_stat_t  stat;

  assign busy   = (state_r != SEQ_IDLE);
  assign accept = start && !busy;

  bbcm_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .clear     (acc_clear),
    .pixel     (in_pixel),
    .width     (width_eff),
    .height    (height_eff),
    .stat      (stat),
    .end_frame (end_frame)
  );

  // ---------------- shared divider ----------------
  logic               div_start;
  logic [SUM_W-1:0]   div_dividend;
  logic               div_done;
  logic [COORD_W-1:0] div_quo;

  bbcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (stat.count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------- sequencer ----------------
  logic [COORD_W-1:0]    cx_r, cx_nxt;
  logic [COORD_W-1:0]    cy_r, cy_nxt;
  logic [LIM_W-1:0]      base_r, base_nxt;
  logic [LIM_W-1:0]      limit_r, limit_nxt;
  logic [OFF_W-1:0]      span_r, span_nxt;
  logic signed [OFF_W-1:0] offset_r, offset_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;

  logic [DIM_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_p;
  logic              in_frame_now;

  logic                    valid_nxt, valid_r;
  logic signed [OFF_W-1:0] o_off_nxt, o_off_r;
  logic                    o_inf_nxt, o_inf_r;
  logic                    o_found_nxt, o_found_r;
  logic                    o_last_nxt, o_last_r;

  // one multiplier, operand picked by state
  always_comb begin
    case (state_r)
      SEQ_MUL_BASE:  mul_a = {1'b0, cy_r};
      SEQ_MUL_LIMIT: mul_a = height_eff;
      default:       mul_a = DIM_W'(ARM_LENGTH);
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(width_eff);
  end

  assign in_frame_now = !offset_r[OFF_W-1] && (offset_r[LIM_W-1:0] < limit_r);

  always_comb begin
    state_nxt    = state_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    base_nxt     = base_r;
    limit_nxt    = limit_r;
    span_nxt     = span_r;
    offset_nxt   = offset_r;
    idx_nxt      = idx_r;
    div_start    = 1'b0;
    div_dividend = stat.col_sum;
    acc_clear    = 1'b0;
    valid_nxt    = 1'b0;
    o_off_nxt    = offset_r;
    o_inf_nxt    = in_frame_now;
    o_found_nxt  = 1'b1;
    o_last_nxt   = 1'b0;

    case (state_r)
      SEQ_IDLE: begin
        if (accept && end_frame) begin
          state_nxt = SEQ_START;
        end
      end
      SEQ_START: begin
        if (stat.count == '0) begin
          state_nxt = SEQ_EMPTY;
        end else begin
          div_start = 1'b1;
          state_nxt = SEQ_DIV_X;
        end
      end
      SEQ_DIV_X: begin
        if (div_done) begin
          cx_nxt       = div_quo;
          div_start    = 1'b1;
          div_dividend = stat.row_sum;
          state_nxt    = SEQ_DIV_Y;
        end
      end
      SEQ_DIV_Y: begin
        div_dividend = stat.row_sum;
        if (div_done) begin
          cy_nxt    = div_quo;
          state_nxt = SEQ_MUL_BASE;
        end
      end
      SEQ_MUL_BASE: begin
        base_nxt  = mul_p[LIM_W-1:0] + LIM_W'(cx_r);
        state_nxt = SEQ_MUL_LIMIT;
      end
      SEQ_MUL_LIMIT: begin
        limit_nxt = mul_p[LIM_W-1:0];
        state_nxt = SEQ_MUL_ARM;
      end
      SEQ_MUL_ARM: begin
        span_nxt   = mul_p[OFF_W-1:0];
        offset_nxt = $signed({1'b0, base_r}) - OFF_W'(ARM_LENGTH);
        idx_nxt    = '0;
        state_nxt  = SEQ_EMIT_ROW;
      end
      SEQ_EMIT_ROW: begin
        valid_nxt = 1'b1;
        if (idx_r == IDX_W'(2 * ARM_LENGTH)) begin
          idx_nxt    = '0;
          offset_nxt = $signed({1'b0, base_r}) - $signed(span_r);
          state_nxt  = SEQ_EMIT_COL;
        end else begin
          idx_nxt    = idx_r + IDX_W'(1);
          offset_nxt = offset_r + OFF_W'(1);
        end
      end
      SEQ_EMIT_COL: begin
        valid_nxt  = 1'b1;
        idx_nxt    = idx_r + IDX_W'(1);
        offset_nxt = offset_r + $signed(OFF_W'(width_eff));
        if (idx_r == IDX_W'(2 * ARM_LENGTH)) begin
          o_last_nxt = 1'b1;
          acc_clear  = 1'b1;
          state_nxt  = SEQ_IDLE;
        end
      end
      SEQ_EMPTY: begin
        // frame without object pixels: a single beat, found low
        valid_nxt   = 1'b1;
        o_off_nxt   = '0;
        o_inf_nxt   = 1'b0;
        o_found_nxt = 1'b0;
        o_last_nxt  = 1'b1;
        cx_nxt      = '0;
        cy_nxt      = '0;
        acc_clear   = 1'b1;
        state_nxt   = SEQ_IDLE;
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    base_r    <= base_nxt;
    limit_r   <= limit_nxt;
    span_r    <= span_nxt;
    offset_r  <= offset_nxt;
    idx_r     <= idx_nxt;
    o_off_r   <= o_off_nxt;
    o_inf_r   <= o_inf_nxt;
    o_found_r <= o_found_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_write_offset = o_off_r;
  assign out_in_frame     = o_inf_r;
  assign out_centroid_x   = cx_r;
  assign out_centroid_y   = cy_r;
  assign out_found        = o_found_r;
  assign out_last         = o_last_r;

endmodule

`default_nettype wire
